// ===== hw/rtl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared codes and types for the bounded deque with positional access.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int ACTION_W = 3;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_REMOVE     = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_READ       = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BADPOS = 2'd3;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } bdq_mem_ctl_t;

endpackage

// ===== hw/rtl/bounded_deque_with_positional_access_top.sv =====
// Push writes its slot in the execute state; pop, read and remove read the slot there and return
// the word from the read state, and a remove then moves each later element down one place.
// One word in flight; the next is taken once the result word has been taken.
// The remove shift works one element at a time: the one slot adder addresses the read, then the write.
// Reset clears the state, the front pointer, the count and the result valid flag; stored words are not cleared.
// ----------------------------------------------------------------------------
// bounded_deque_with_positional_access_top
// Ring-buffer deque with a small sequencer driving one shared slot adder.
// ----------------------------------------------------------------------------
module bounded_deque_with_positional_access_top #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic [bdq_pkg::ACTION_W-1:0]    action,
    input  logic [bdq_pkg::WORD_W-1:0]      write_data,
    input  logic [bdq_pkg::POS_W-1:0]       position,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output logic [bdq_pkg::WORD_W-1:0]      read_data,
    output logic [bdq_pkg::STATUS_W-1:0]    status,
    output logic [bdq_pkg::COUNT_W-1:0]     element_count
);
    import bdq_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_SH_RD = 3'd3;
    localparam logic [2:0] S_SH_WR = 3'd4;

    logic [2:0]            state_reg,     state_next;
    logic [AW-1:0]         front_reg,     front_next;
    logic [CW-1:0]         count_reg,     count_next;
    logic [AW-1:0]         k_reg,         k_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [WORD_W-1:0]     rdata_reg,     rdata_next;
    logic [STATUS_W-1:0]   status_reg,    status_next;

    logic [ACTION_W-1:0]   act_reg;
    logic [DATA_WIDTH-1:0] wdata_reg;
    logic [POS_W-1:0]      pos_reg;

    logic [AW-1:0]         offset;
    logic [AW-1:0]         slot;
    bdq_mem_ctl_t          mem_ctl;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [DATA_WIDTH-1:0] mem_rdata;
    logic [63:0]           rd_wide;
    logic [WORD_W-1:0]     rd_word;
    logic                  is_full;
    logic                  is_empty;
    logic                  pos_bad;
    logic                  accept;

    bdq_slot_unit #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_slot (
        .base   (front_reg),
        .offset (offset),
        .slot   (slot)
    );

    bdq_store #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (DATA_WIDTH)
    ) u_store (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (slot),
        .wdata (mem_wdata),
        .raddr (slot),
        .rdata (mem_rdata)
    );

    assign req_ready     = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign accept        = req_valid && req_ready;
    assign rsp_valid     = rsp_valid_reg;
    assign read_data     = rdata_reg;
    assign status        = status_reg;
    assign element_count = COUNT_W'(count_reg);

    assign rd_wide  = 64'(mem_rdata);
    assign rd_word  = rd_wide[WORD_W-1:0];
    assign is_full  = (count_reg == CW'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign pos_bad  = (CMPW'(pos_reg) >= CMPW'(count_reg));

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rdata_next     = rdata_reg;
        status_next    = status_reg;
        offset         = '0;
        mem_ctl        = '0;
        mem_wdata      = wdata_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                rdata_next  = '0;
                status_next = STAT_OK;
                case (act_reg)
                    ACT_PUSH_FRONT, ACT_PUSH_BACK:
                    begin
                        offset = (act_reg == ACT_PUSH_FRONT) ? AW'(CAPACITY - 1)
                                                             : count_reg[AW-1:0];
                        state_next     = S_IDLE;
                        rsp_valid_next = 1'b1;
                        if (is_full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            mem_ctl.wr_en = 1'b1;
                            count_next    = count_reg + CW'(1);
                            if (act_reg == ACT_PUSH_FRONT)
                            begin
                                front_next = slot;
                            end
                        end
                    end
                    ACT_POP_FRONT, ACT_POP_BACK:
                    begin
                        offset = (act_reg == ACT_POP_BACK) ? AW'(count_reg - CW'(1)) : '0;
                        if (is_empty)
                        begin
                            status_next    = STAT_EMPTY;
                            state_next     = S_IDLE;
                            rsp_valid_next = 1'b1;
                        end
                        else
                        begin
                            mem_ctl.rd_en = 1'b1;
                            state_next    = S_READ;
                        end
                    end
                    ACT_REMOVE, ACT_READ:
                    begin
                        offset = AW'(pos_reg);
                        k_next = AW'(pos_reg);
                        if (pos_bad)
                        begin
                            status_next    = STAT_BADPOS;
                            state_next     = S_IDLE;
                            rsp_valid_next = 1'b1;
                        end
                        else
                        begin
                            mem_ctl.rd_en = 1'b1;
                            state_next    = S_READ;
                        end
                    end
                    default:
                    begin
                        state_next     = S_IDLE;
                        rsp_valid_next = 1'b1;
                    end
                endcase
            end
            S_READ:
            begin
                rdata_next = rd_word;
                if (act_reg == ACT_POP_FRONT)
                begin
                    offset     = AW'(1);
                    front_next = slot;
                end
                if ((act_reg == ACT_REMOVE) && ((CW'(k_reg) + CW'(1)) < count_reg))
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    if (act_reg != ACT_READ)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            S_SH_RD:
            begin
                offset        = k_reg + AW'(1);
                mem_ctl.rd_en = 1'b1;
                state_next    = S_SH_WR;
            end
            S_SH_WR:
            begin
                offset        = k_reg;
                mem_ctl.wr_en = 1'b1;
                mem_wdata     = mem_rdata;
                k_next        = k_reg + AW'(1);
                if ((CW'(k_reg) + CW'(2)) < count_reg)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    count_next     = count_reg - CW'(1);
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        rdata_reg  <= rdata_next;
        status_reg <= status_next;
        if (accept)
        begin
            act_reg   <= action;
            wdata_reg <= DATA_WIDTH'(write_data);
            pos_reg   <= position;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (status_reg == STAT_FULL)) |-> is_full)
        else $error("full status while not full");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (status_reg == STAT_EMPTY)) |-> is_empty)
        else $error("empty status while not empty");

    a_rsp_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) != S_IDLE))
        else $error("result word raised without a request in progress");
`endif

endmodule

// ===== hw/rtl/bdq_slot_unit.sv =====
// ----------------------------------------------------------------------------
// bdq_slot_unit
// Shared modular adder: maps a base slot plus an offset onto the ring.
// ----------------------------------------------------------------------------
module bdq_slot_unit #(
    parameter int CAPACITY = 16,
    parameter int AW       = 4
) (
    input  logic [AW-1:0] base,
    input  logic [AW-1:0] offset,
    output logic [AW-1:0] slot
);

    logic [AW:0] sum;
    logic [AW:0] wrapped;

    assign sum     = {1'b0, base} + {1'b0, offset};
    assign wrapped = sum - (AW+1)'(CAPACITY);
    assign slot    = (sum >= (AW+1)'(CAPACITY)) ? wrapped[AW-1:0] : sum[AW-1:0];

endmodule

// ===== hw/rtl/bdq_store.sv =====
// ----------------------------------------------------------------------------
// bdq_store
// Element memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bdq_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 32
) (
    input  logic                  clk,
    input  bdq_pkg::bdq_mem_ctl_t ctl,
    input  logic [AW-1:0]         waddr,
    input  logic [DW-1:0]         wdata,
    input  logic [AW-1:0]         raddr,
    output logic [DW-1:0]         rdata
);
    import bdq_pkg::*;

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== tb/bounded_deque_with_positional_access_top_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_positional_access_top_tb
// Drives push, pop, remove, read and reserved-code requests into the deque and checks every
// result word against a shadow deque kept in the bench, with random gaps and
// back-pressure on both sides.
// ----------------------------------------------------------------------------
module bounded_deque_with_positional_access_top_tb;

    import bdq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int STALL_LIMIT = 1000;

    // codes with no defined action; the deque must leave its state alone
    localparam logic [ACTION_W-1:0] ACT_RSVD6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_RSVD7 = 3'd7;

    typedef struct packed {
        logic [WORD_W-1:0]   data;
        logic [STATUS_W-1:0] stat;
        logic [COUNT_W-1:0]  count;
    } bdq_rsp_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                req_valid  = 1'b0;
    logic                req_ready;
    logic [ACTION_W-1:0] action     = '0;
    logic [WORD_W-1:0]   write_data = '0;
    logic [POS_W-1:0]    position   = '0;
    logic                rsp_valid;
    logic                rsp_ready  = 1'b0;
    logic [WORD_W-1:0]   read_data;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  element_count;

    logic [WORD_W-1:0]   shadow_words [DEPTH];
    logic [POS_W-1:0]    shadow_front = '0;
    logic [COUNT_W-1:0]  shadow_count = '0;
    bdq_rsp_t            pending_rsp [$];
    int                  fail_count   = 0;
    int                  rsp_hold     = 0;
    bit                  no_idle      = 1'b0;

    bounded_deque_with_positional_access_top #(
        .CAPACITY   (DEPTH),
        .DATA_WIDTH (WORD_W)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .action        (action),
        .write_data    (write_data),
        .position      (position),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .read_data     (read_data),
        .status        (status),
        .element_count (element_count)
    );

    always #4 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (no_idle)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [POS_W-1:0] slot_at(input logic [COUNT_W-1:0] offset);
        logic [COUNT_W-1:0] sum;
        sum = shadow_front + offset;
        return sum[POS_W-1:0];
    endfunction

    // applies one request to the shadow deque and returns the result word
    function automatic bdq_rsp_t deque_apply(input logic [ACTION_W-1:0] act,
                                             input logic [WORD_W-1:0]   wd,
                                             input logic [POS_W-1:0]    pos);
        bdq_rsp_t r;
        int       k;
        r.data = '0;
        r.stat = STAT_OK;
        case (act)
            ACT_PUSH_FRONT:
            begin
                if (shadow_count >= DEPTH)
                begin
                    r.stat = STAT_FULL;
                end
                else
                begin
                    shadow_front = shadow_front - 1'b1;
                    shadow_words[shadow_front] = wd;
                    shadow_count++;
                end
            end
            ACT_PUSH_BACK:
            begin
                if (shadow_count >= DEPTH)
                begin
                    r.stat = STAT_FULL;
                end
                else
                begin
                    shadow_words[slot_at(shadow_count)] = wd;
                    shadow_count++;
                end
            end
            ACT_POP_FRONT:
            begin
                if (shadow_count == 0)
                begin
                    r.stat = STAT_EMPTY;
                end
                else
                begin
                    r.data = shadow_words[shadow_front];
                    shadow_front = shadow_front + 1'b1;
                    shadow_count--;
                end
            end
            ACT_POP_BACK:
            begin
                if (shadow_count == 0)
                begin
                    r.stat = STAT_EMPTY;
                end
                else
                begin
                    r.data = shadow_words[slot_at(shadow_count - 1'b1)];
                    shadow_count--;
                end
            end
            ACT_REMOVE:
            begin
                if (COUNT_W'(pos) >= shadow_count)
                begin
                    r.stat = STAT_BADPOS;
                end
                else
                begin
                    r.data = shadow_words[slot_at(COUNT_W'(pos))];
                    for (k = int'(pos); k + 1 < shadow_count; k++)
                    begin
                        shadow_words[slot_at(COUNT_W'(k))] =
                            shadow_words[slot_at(COUNT_W'(k + 1))];
                    end
                    shadow_count--;
                end
            end
            ACT_READ:
            begin
                if (COUNT_W'(pos) >= shadow_count)
                begin
                    r.stat = STAT_BADPOS;
                end
                else
                begin
                    r.data = shadow_words[slot_at(COUNT_W'(pos))];
                end
            end
            default:
            begin
            end
        endcase
        r.count = shadow_count;
        return r;
    endfunction

    task automatic send_word(input logic [ACTION_W-1:0] act,
                             input logic [WORD_W-1:0]   wd,
                             input logic [POS_W-1:0]    pos);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid  <= 1'b1;
        action     <= act;
        write_data <= wd;
        position   <= pos;
        do @(posedge clk); while (!req_ready);
        pending_rsp.push_back(deque_apply(act, wd, pos));
    endtask

    // sender holds off until every outstanding result word is back
    task automatic drain_results();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending_rsp.size() != 0);
    endtask

    task automatic test_empty_list();
        send_word(ACT_POP_FRONT, '0, '0);
        send_word(ACT_POP_BACK, '1, '1);
        send_word(ACT_REMOVE, '0, '0);
        send_word(ACT_READ, $urandom, '1);
    endtask

    task automatic test_reserved_actions();
        send_word(ACT_RSVD6, '1, '1);
        send_word(ACT_RSVD7, '0, '0);
    endtask

    task automatic test_fill_to_capacity();
        int               i;
        logic [WORD_W-1:0] wd;
        for (i = 0; i < DEPTH; i++)
        begin
            wd = (i == 0) ? '0 : (i == 1) ? '1 : $urandom;
            send_word((i % 2) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, wd, POS_W'($urandom));
        end
        send_word(ACT_PUSH_FRONT, $urandom, POS_W'($urandom));
        send_word(ACT_PUSH_BACK, $urandom, POS_W'($urandom));
    endtask

    task automatic test_trim_at_capacity();
        send_word(ACT_READ, $urandom, 4'd15);
        send_word(ACT_REMOVE, $urandom, 4'd15);
        send_word(ACT_REMOVE, $urandom, 4'd0);
        send_word(ACT_READ, $urandom, 4'd15);
    endtask

    // sweeps the count between empty and full; remove_pct steers the mix
    task automatic test_random_traffic(input int n_words, input int remove_pct);
        int                i;
        int                r;
        bit                filling;
        logic [ACTION_W-1:0] act;
        logic [POS_W-1:0]  pos;
        filling = 1'b1;
        for (i = 0; i < n_words; i++)
        begin
            if (shadow_count == DEPTH)
            begin
                filling = 1'b0;
            end
            else if (shadow_count == 0)
            begin
                filling = 1'b1;
            end
            else if ($urandom_range(0, 99) < 4)
            begin
                filling = ~filling;
            end
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                act = $urandom_range(0, 1) ? ACT_RSVD6 : ACT_RSVD7;
            end
            else if (r < 3 + remove_pct)
            begin
                act = ACT_REMOVE;
            end
            else if (r < 60)
            begin
                if (filling)
                begin
                    act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
                end
                else
                begin
                    act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
                end
            end
            else if (r < 75)
            begin
                if (filling)
                begin
                    act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
                end
                else
                begin
                    act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
                end
            end
            else
            begin
                act = ACT_READ;
            end
            if (shadow_count != 0 && $urandom_range(0, 99) < 80)
            begin
                pos = POS_W'($urandom_range(0, shadow_count - 1));
            end
            else
            begin
                pos = POS_W'($urandom_range(0, DEPTH - 1));
            end
            send_word(act, $urandom, pos);
        end
    endtask

    task automatic test_back_to_back(input int n_words);
        no_idle = 1'b1;
        test_random_traffic(n_words, 15);
        drain_results();
        no_idle = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            rsp_hold = 0;
        end
        else if (rsp_hold > 0)
        begin
            rsp_hold--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
            begin
                rsp_hold = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        bdq_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected word: read_data %h status %0d count %0d",
                         $time, read_data, status, element_count);
                fail_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (read_data !== want.data)
                begin
                    $display("%0t: read_data expected %h actual %h",
                             $time, want.data, read_data);
                    fail_count++;
                end
                if (status !== want.stat)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.stat, status);
                    fail_count++;
                end
                if (element_count !== want.count)
                begin
                    $display("%0t: element_count expected %0d actual %0d",
                             $time, want.count, element_count);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: too long with no word moving on either side
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("%0t: timeout, %0d words outstanding", $time, pending_rsp.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_reserved_actions();
        test_fill_to_capacity();
        test_trim_at_capacity();
        drain_results();
        test_random_traffic(280, 12);
        drain_results();
        test_back_to_back(120);
        test_random_traffic(220, 35);
        drain_results();
        repeat (40) @(posedge clk);
        if (pending_rsp.size() != 0)
        begin
            fail_count++;
        end
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
